// ===== rtl/rlm_pkg.sv =====
// Shared constants, codes and types of the repetition latency monitor.
package rlm_pkg;

  // Field widths.
  localparam int EVENT_COUNT_WIDTH = 32;
  localparam int DATA_W  = 64;
  localparam int FREQ_W  = 32;
  localparam int KIND_W  = 3;
  localparam int PHASE_W = 2;
  localparam int ERR_W   = 3;
  // Three times a 32-bit frequency never needs more than two extra bits.
  localparam int LIMIT_W = FREQ_W + 2;

  // Stream widths: input data holds timer, fault, amount, frequency.
  localparam int IN_TDATA_W   = 3 * DATA_W + FREQ_W;
  localparam int OUT_FIELDS_W = PHASE_W + 1 + ERR_W + 1 + 8 * DATA_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Event kinds.
  localparam logic [KIND_W-1:0] KIND_START = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BEGIN = 3'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BYTES = 3'd3;
  localparam logic [KIND_W-1:0] KIND_POLL  = 3'd4;

  // Test phases.
  localparam logic [PHASE_W-1:0] PH_NONE     = 2'd0;
  localparam logic [PHASE_W-1:0] PH_TESTING  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_ERROR    = 2'd2;
  localparam logic [PHASE_W-1:0] PH_FINISHED = 2'd3;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
  localparam logic [ERR_W-1:0] ERR_FREQ       = 3'd1;
  localparam logic [ERR_W-1:0] ERR_EXPECTED   = 3'd2;
  localparam logic [ERR_W-1:0] ERR_UNBALANCED = 3'd3;
  localparam logic [ERR_W-1:0] ERR_BYTES      = 3'd4;

  // One registered event request.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] timer_value;
    logic [DATA_W-1:0] fault_value;
    logic [DATA_W-1:0] amount;
    logic [FREQ_W-1:0] frequency;
  } rlm_event_t;

  // One status result.
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               still_testing;
    logic [ERR_W-1:0]   error_code;
    logic               new_minimum;
    logic [DATA_W-1:0]  min_ticks;
    logic [DATA_W-1:0]  min_bytes;
    logic [DATA_W-1:0]  min_faults;
    logic [DATA_W-1:0]  max_ticks;
    logic [DATA_W-1:0]  total_ticks;
    logic [DATA_W-1:0]  total_bytes;
    logic [DATA_W-1:0]  total_faults;
    logic [DATA_W-1:0]  total_runs;
  } rlm_result_t;

endpackage

// ===== rtl/rlm_in_stage.sv =====
// Input register of the monitor: unpacks and holds one event request.
module rlm_in_stage
  import rlm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [KIND_W-1:0]     in_tuser,
  input  logic                  advance,
  output logic                  ev_valid,
  output rlm_event_t            ev
);

  logic       valid_r, valid_nxt;
  rlm_event_t ev_r;
  logic       accept;

  // The stage takes a new request whenever it is empty or its content moves on this cycle.
  assign in_tready = !valid_r || advance;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload fields, lowest field in the lowest bits.
  always_ff @(posedge clk) begin
    if (accept) begin
      ev_r.kind        <= in_tuser;
      ev_r.timer_value <= in_tdata[DATA_W-1:0];
      ev_r.fault_value <= in_tdata[2*DATA_W-1:DATA_W];
      ev_r.amount      <= in_tdata[3*DATA_W-1:2*DATA_W];
      ev_r.frequency   <= in_tdata[3*DATA_W+FREQ_W-1:3*DATA_W];
    end
  end

  assign ev_valid = valid_r;
  assign ev       = ev_r;

endmodule

// ===== rtl/rlm_core.sv =====
// Monitor state and the single-pass update that one event applies to it.
module rlm_core
  import rlm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  rlm_event_t  ev,
  output rlm_result_t res
);

  logic [PHASE_W-1:0]           phase_r, phase_nxt;
  logic [ERR_W-1:0]             err_r, err_nxt;
  logic [LIMIT_W-1:0]           limit_r, limit_nxt;
  logic [DATA_W-1:0]            expected_r, expected_nxt;
  logic [FREQ_W-1:0]            freq_r, freq_nxt;
  logic [DATA_W-1:0]            stamp_r, stamp_nxt;
  logic [EVENT_COUNT_WIDTH-1:0] begins_r, begins_nxt;
  logic [EVENT_COUNT_WIDTH-1:0] ends_r, ends_nxt;
  logic                         cur_count_r, cur_count_nxt;
  logic [DATA_W-1:0]            cur_ticks_r, cur_ticks_nxt;
  logic [DATA_W-1:0]            cur_bytes_r, cur_bytes_nxt;
  logic [DATA_W-1:0]            cur_faults_r, cur_faults_nxt;
  logic [DATA_W-1:0]            tot_runs_r, tot_runs_nxt;
  logic [DATA_W-1:0]            tot_ticks_r, tot_ticks_nxt;
  logic [DATA_W-1:0]            tot_bytes_r, tot_bytes_nxt;
  logic [DATA_W-1:0]            tot_faults_r, tot_faults_nxt;
  logic [DATA_W-1:0]            min_ticks_r, min_ticks_nxt;
  logic [DATA_W-1:0]            min_bytes_r, min_bytes_nxt;
  logic [DATA_W-1:0]            min_faults_r, min_faults_nxt;
  logic [DATA_W-1:0]            max_ticks_r, max_ticks_nxt;

  logic               fresh;
  logic               run_ok;
  logic               is_lo, is_hi;
  logic               timed_out;
  logic [DATA_W-1:0]  elapsed;
  logic [LIMIT_W-1:0] limit_new;

  // Checks used by a poll; all work in parallel on the current state.
  assign is_lo     = cur_ticks_r < min_ticks_r;
  assign is_hi     = cur_ticks_r > max_ticks_r;
  assign elapsed   = ev.timer_value - stamp_r;
  assign timed_out = elapsed > {{(DATA_W-LIMIT_W){1'b0}}, limit_r};
  assign run_ok    = (begins_r == ends_r) && (cur_bytes_r == expected_r);
  assign limit_new = {2'b00, ev.frequency} + {1'b0, ev.frequency, 1'b0};

  always_comb begin
    phase_nxt      = phase_r;
    err_nxt        = err_r;
    limit_nxt      = limit_r;
    expected_nxt   = expected_r;
    freq_nxt       = freq_r;
    stamp_nxt      = stamp_r;
    begins_nxt     = begins_r;
    ends_nxt       = ends_r;
    cur_count_nxt  = cur_count_r;
    cur_ticks_nxt  = cur_ticks_r;
    cur_bytes_nxt  = cur_bytes_r;
    cur_faults_nxt = cur_faults_r;
    tot_runs_nxt   = tot_runs_r;
    tot_ticks_nxt  = tot_ticks_r;
    tot_bytes_nxt  = tot_bytes_r;
    tot_faults_nxt = tot_faults_r;
    min_ticks_nxt  = min_ticks_r;
    min_bytes_nxt  = min_bytes_r;
    min_faults_nxt = min_faults_r;
    max_ticks_nxt  = max_ticks_r;
    fresh          = 1'b0;

    case (ev.kind)
      KIND_START: begin
        if (phase_r == PH_NONE) begin
          phase_nxt     = PH_TESTING;
          freq_nxt      = ev.frequency;
          limit_nxt     = limit_new;
          expected_nxt  = ev.amount;
          min_ticks_nxt = '1;
        end else if (phase_r == PH_FINISHED) begin
          // A changed expected total takes precedence over a changed frequency.
          phase_nxt = PH_TESTING;
          if (freq_r != ev.frequency) begin
            phase_nxt = PH_ERROR;
            err_nxt   = ERR_FREQ;
          end
          if (expected_r != ev.amount) begin
            phase_nxt = PH_ERROR;
            err_nxt   = ERR_EXPECTED;
          end
        end
        stamp_nxt     = ev.timer_value;
        cur_count_nxt = 1'b1;
      end
      KIND_BEGIN: begin
        begins_nxt     = begins_r + 1'b1;
        cur_ticks_nxt  = cur_ticks_r - ev.timer_value;
        cur_faults_nxt = cur_faults_r - ev.fault_value;
      end
      KIND_END: begin
        ends_nxt       = ends_r + 1'b1;
        cur_ticks_nxt  = cur_ticks_r + ev.timer_value;
        cur_faults_nxt = cur_faults_r + ev.fault_value;
      end
      KIND_BYTES: begin
        cur_bytes_nxt = cur_bytes_r + ev.amount;
      end
      KIND_POLL: begin
        if (phase_r == PH_TESTING) begin
          if (begins_r != '0) begin
            // A byte mismatch overrides an unbalanced begin/end count.
            if (begins_r != ends_r) begin
              phase_nxt = PH_ERROR;
              err_nxt   = ERR_UNBALANCED;
            end
            if (cur_bytes_r != expected_r) begin
              phase_nxt = PH_ERROR;
              err_nxt   = ERR_BYTES;
            end
            // A clean run goes into the totals and the min and max records.
            if (run_ok) begin
              tot_runs_nxt   = tot_runs_r + {{(DATA_W-1){1'b0}}, cur_count_r};
              tot_ticks_nxt  = tot_ticks_r + cur_ticks_r;
              tot_bytes_nxt  = tot_bytes_r + cur_bytes_r;
              tot_faults_nxt = tot_faults_r + cur_faults_r;
              if (is_lo) begin
                min_ticks_nxt  = cur_ticks_r;
                min_bytes_nxt  = cur_bytes_r;
                min_faults_nxt = cur_faults_r;
                stamp_nxt      = ev.timer_value;
                fresh          = 1'b1;
              end
              if (is_hi) begin
                max_ticks_nxt = cur_ticks_r;
              end
              begins_nxt     = '0;
              ends_nxt       = '0;
              cur_count_nxt  = 1'b1;
              cur_ticks_nxt  = '0;
              cur_bytes_nxt  = '0;
              cur_faults_nxt = '0;
            end
          end
          // The timeout also applies on a poll that flags an error; a fresh minimum restarts it.
          if (!fresh && timed_out) begin
            phase_nxt = PH_FINISHED;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_NONE;
      err_r        <= ERR_NONE;
      limit_r      <= '0;
      expected_r   <= '0;
      freq_r       <= '0;
      stamp_r      <= '0;
      begins_r     <= '0;
      ends_r       <= '0;
      cur_count_r  <= 1'b0;
      cur_ticks_r  <= '0;
      cur_bytes_r  <= '0;
      cur_faults_r <= '0;
      tot_runs_r   <= '0;
      tot_ticks_r  <= '0;
      tot_bytes_r  <= '0;
      tot_faults_r <= '0;
      min_ticks_r  <= '0;
      min_bytes_r  <= '0;
      min_faults_r <= '0;
      max_ticks_r  <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      err_r        <= err_nxt;
      limit_r      <= limit_nxt;
      expected_r   <= expected_nxt;
      freq_r       <= freq_nxt;
      stamp_r      <= stamp_nxt;
      begins_r     <= begins_nxt;
      ends_r       <= ends_nxt;
      cur_count_r  <= cur_count_nxt;
      cur_ticks_r  <= cur_ticks_nxt;
      cur_bytes_r  <= cur_bytes_nxt;
      cur_faults_r <= cur_faults_nxt;
      tot_runs_r   <= tot_runs_nxt;
      tot_ticks_r  <= tot_ticks_nxt;
      tot_bytes_r  <= tot_bytes_nxt;
      tot_faults_r <= tot_faults_nxt;
      min_ticks_r  <= min_ticks_nxt;
      min_bytes_r  <= min_bytes_nxt;
      min_faults_r <= min_faults_nxt;
      max_ticks_r  <= max_ticks_nxt;
    end
  end

  // Status after this event.
  always_comb begin
    res.phase         = phase_nxt;
    res.still_testing = (phase_nxt == PH_TESTING);
    res.error_code    = err_nxt;
    res.new_minimum   = fresh;
    res.min_ticks     = min_ticks_nxt;
    res.min_bytes     = min_bytes_nxt;
    res.min_faults    = min_faults_nxt;
    res.max_ticks     = max_ticks_nxt;
    res.total_ticks   = tot_ticks_nxt;
    res.total_bytes   = tot_bytes_nxt;
    res.total_faults  = tot_faults_nxt;
    res.total_runs    = tot_runs_nxt;
  end

endmodule

// ===== rtl/repetition_latency_monitor.sv =====
// Top level of the repetition latency monitor: input stage, update logic, result register.
// An accepted request passes through the input register and then the result register.
// One event per cycle unless out_tready stalls; the update is one pass of the state logic.
// The input register and the result register hold their contents while the output stalls.
// Reset (rst_n low, synchronous) empties both stages and returns all core state to zero.
module repetition_latency_monitor
  import rlm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // timer_value, fault_value, amount, frequency
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // kind
  input  logic [KIND_W-1:0]      in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // phase, still_testing, error_code, new_minimum, min_ticks, min_bytes,
  // min_faults, max_ticks, total_ticks, total_bytes, total_faults, total_runs, pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic        ev_valid;
  rlm_event_t  ev;
  rlm_result_t res;
  rlm_result_t res_r;
  logic        out_valid_r, out_valid_nxt;
  logic        advance;
  logic        fire;

  // The held event moves on whenever the result register is free or drains.
  assign advance = !out_valid_r || out_tready;
  assign fire    = ev_valid && advance;

  rlm_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .advance   (advance),
    .ev_valid  (ev_valid),
    .ev        (ev)
  );

  rlm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .ev    (ev),
    .res   (res)
  );

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  // Pack the result, first field in the lowest bits.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                       res_r.total_runs, res_r.total_faults, res_r.total_bytes,
                       res_r.total_ticks, res_r.max_ticks, res_r.min_faults,
                       res_r.min_bytes, res_r.min_ticks, res_r.new_minimum,
                       res_r.error_code, res_r.still_testing, res_r.phase};

  // A new minimum only comes from a clean poll that leaves the test running.
  a_newmin_testing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.new_minimum |-> res_r.phase == PH_TESTING)
    else $error("new minimum reported outside the testing phase");

  // A recorded error is never cleared by later events.
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.error_code != ERR_NONE |=> res_r.error_code != ERR_NONE)
    else $error("error code cleared without reset");

  // No run can be recorded before the first start wave.
  a_none_no_runs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.phase == PH_NONE |-> res_r.total_runs == '0)
    else $error("runs recorded while no test has started");

endmodule
